/* rtl/smc_pkg.sv */
// Shared types, widths and helpers for the sliding mode speed controller.
// No dependencies; imported by smc_mul, the top level and the checker.
`default_nettype none

package smc_pkg;

    // Field and datapath widths (fixed by the Q formats)
    localparam int SPEED_W   = 32;             // Q16.16 port fields
    localparam int FRIC_W    = 31;             // B/J, Np/J registers
    localparam int ERR_W     = SPEED_W + 1;    // speed error
    localparam int INTEG_W   = 48;             // Q16.32 integrator
    localparam int SIGMA_W   = 48;             // full-precision surface
    localparam int SUM_W     = 50;             // switching gain sum
    localparam int MU_W      = 50;             // switching gain
    localparam int CMD_W     = 64;             // unsaturated command
    localparam int PVAL_W    = 64;             // signed, rescaled product

    // Digit-serial multiplier: A_W-bit magnitude times B_W-bit magnitude,
    // DIGIT_W bits of B consumed per cycle.
    localparam int A_W       = 49;
    localparam int B_W       = 32;
    localparam int DIGIT_W   = 8;
    localparam int P_W       = A_W + B_W;
    localparam int PART_W    = A_W + DIGIT_W;
    localparam int MUL_STEPS = B_W / DIGIT_W;
    localparam int CNT_W     = $clog2(MUL_STEPS);

    // Product rescaling points
    localparam int SHIFT_LO  = 16;
    localparam int SHIFT_HI  = 32;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_SURFACE_GAIN        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROPORTIONAL_GAIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DISTURBANCE_BOUND   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INVERSE_TORQUE_GAIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FRICTION_RATIO      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_POLE_INERTIA_RATIO  = 3'd6;

    // Register reset values
    localparam logic [SPEED_W-1:0] SAMPLE_PERIOD_RST  = 32'd429497;   // 1e-4 s
    localparam logic [SPEED_W-1:0] INV_TORQUE_RST     = 32'd22184748;
    localparam logic [FRIC_W-1:0]  POLE_INERTIA_RST   = 31'd26214400; // 400.0

    // Sequencer: an idle state plus one state per product
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INT,     // e * dt            -> integrator
        ST_SURF,    // c * integral      -> sigma
        ST_FRIC,    // B/J * |omega|     -> sum
        ST_DIST,    // Np/J * phi        -> sum
        ST_ERR,     // c * |e|           -> sum
        ST_MU,      // inv_a * sum       -> mu
        ST_GAMMA    // gamma * sigma     -> command
    } smc_state_t;

    // Saturate a wide signed value to the 32-bit output range
    function automatic logic signed [SPEED_W-1:0] sat_out(input logic signed [CMD_W-1:0] v);
        logic hi_zero;
        logic hi_ones;
        hi_zero = ~|v[CMD_W-1:SPEED_W-1];
        hi_ones = &v[CMD_W-1:SPEED_W-1];
        if (hi_zero || hi_ones)
        begin
            sat_out = v[SPEED_W-1:0];
        end
        else if (v[CMD_W-1])
        begin
            sat_out = {1'b1, {(SPEED_W-1){1'b0}}};
        end
        else
        begin
            sat_out = {1'b0, {(SPEED_W-1){1'b1}}};
        end
    endfunction

endpackage

`default_nettype wire

/* rtl/sliding_mode_speed_controller.sv */
// Integral sliding mode speed controller, top level: sequencer, state, config.
// Depends on smc_pkg and smc_mul.
//
// Input channel (in_valid/in_stall) takes one speed sample: speed_target and
// speed_measured, Q16.16. Each transfer yields one result on the output
// channel (out_valid/out_stall): the current command and surface computed
// from the previous sample, zero for the first sample after reset. The
// result is registered and appears in the cycle after the input transfer.
// The new sample is then worked through seven products on one shared 49x8
// digit-serial multiplier (4 digit steps plus load and hand-off per
// product), so in_stall stays high until the last product is done and no
// new sample is taken before the previous one is through.
// A result held by out_stall keeps its value; in_stall stays high while it
// waits, so no result is lost.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes one gain
// register per transfer; ready only between samples. Unknown indexes are
// dropped. Reset (rst_n, async) clears the integrator and the held results
// and loads the default gains.
`default_nettype none

module sliding_mode_speed_controller
    import smc_pkg::*;
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic signed [SPEED_W-1:0]   speed_target,
    input  wire logic signed [SPEED_W-1:0]   speed_measured,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic signed [SPEED_W-1:0]        current_command,
    output logic signed [SPEED_W-1:0]        surface_value,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [SPEED_W-1:0]          cfg_data
);

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    smc_state_t state_reg, state_next;
    logic       kick_reg, kick_next;       // start pulse for the multiplier
    logic       out_valid_reg, out_valid_next;

    logic signed [SPEED_W-1:0] out_cmd_reg, out_cmd_next;
    logic signed [SPEED_W-1:0] out_surf_reg, out_surf_next;

    // gain registers
    logic signed [SPEED_W-1:0] surface_gain_reg, surface_gain_next;
    logic signed [SPEED_W-1:0] proportional_gain_reg, proportional_gain_next;
    logic signed [SPEED_W-1:0] disturbance_bound_reg, disturbance_bound_next;
    logic [SPEED_W-1:0]        sample_period_reg, sample_period_next;
    logic [SPEED_W-1:0]        inv_torque_reg, inv_torque_next;
    logic [FRIC_W-1:0]         friction_ratio_reg, friction_ratio_next;
    logic [FRIC_W-1:0]         pole_inertia_reg, pole_inertia_next;

    // controller state
    logic signed [INTEG_W-1:0] integ_reg, integ_next;
    logic signed [SPEED_W-1:0] held_cmd_reg, held_cmd_next;
    logic signed [SPEED_W-1:0] held_surf_reg, held_surf_next;

    // per-sample working registers
    logic signed [SPEED_W-1:0] omega_reg, omega_next;
    logic signed [ERR_W-1:0]   err_reg, err_next;
    logic signed [SIGMA_W-1:0] sigma_reg, sigma_next;
    logic signed [SUM_W-1:0]   sum_reg, sum_next;
    logic signed [MU_W-1:0]    mu_reg, mu_next;

    // ---------------------------------------------------------------
    // Handshakes
    // ---------------------------------------------------------------
    logic wait_out;
    logic in_xfer;
    logic out_xfer;
    logic cfg_xfer;

    assign wait_out = out_valid_reg && out_stall;
    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid_reg && !out_stall;
    assign cfg_xfer = cfg_valid && cfg_ready;

    // ---------------------------------------------------------------
    // Multiplier and its operand selection
    // ---------------------------------------------------------------
    logic           mul_done;
    logic [P_W-1:0] mul_prod;
    logic [A_W-1:0] op_a;
    logic [B_W-1:0] op_b;
    logic           op_neg;      // sign of the signed product
    logic           op_hi;       // rescale by 2^-32 instead of 2^-16

    smc_mul u_smc_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (kick_reg),
        .a       (op_a),
        .b       (op_b),
        .done    (mul_done),
        .product (mul_prod)
    );

    // magnitudes of the signed operands
    logic               err_neg, integ_neg, gain_neg, gamma_neg;
    logic               omega_neg, phi_neg, sum_neg, sigma_neg;
    logic [ERR_W-1:0]   err_mag;
    logic [INTEG_W-1:0] integ_mag;
    logic [SPEED_W-1:0] gain_mag, gamma_mag, omega_mag, phi_mag;
    logic [SUM_W-1:0]   sum_mag;
    logic [SIGMA_W-1:0] sigma_mag;

    assign err_neg   = err_reg[ERR_W-1];
    assign integ_neg = integ_reg[INTEG_W-1];
    assign gain_neg  = surface_gain_reg[SPEED_W-1];
    assign gamma_neg = proportional_gain_reg[SPEED_W-1];
    assign omega_neg = omega_reg[SPEED_W-1];
    assign phi_neg   = disturbance_bound_reg[SPEED_W-1];
    assign sum_neg   = sum_reg[SUM_W-1];
    assign sigma_neg = sigma_reg[SIGMA_W-1];

    assign err_mag   = err_neg   ? $unsigned(-err_reg)               : $unsigned(err_reg);
    assign integ_mag = integ_neg ? $unsigned(-integ_reg)             : $unsigned(integ_reg);
    assign gain_mag  = gain_neg  ? $unsigned(-surface_gain_reg)      : $unsigned(surface_gain_reg);
    assign gamma_mag = gamma_neg ? $unsigned(-proportional_gain_reg) :
                                   $unsigned(proportional_gain_reg);
    assign omega_mag = omega_neg ? $unsigned(-omega_reg)             : $unsigned(omega_reg);
    assign phi_mag   = phi_neg   ? $unsigned(-disturbance_bound_reg) :
                                   $unsigned(disturbance_bound_reg);
    assign sum_mag   = sum_neg   ? $unsigned(-sum_reg)               : $unsigned(sum_reg);
    assign sigma_mag = sigma_neg ? $unsigned(-sigma_reg)             : $unsigned(sigma_reg);

    always_comb
    begin
        op_a   = '0;
        op_b   = '0;
        op_neg = 1'b0;
        op_hi  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                op_a = '0;
            end
            ST_INT:
            begin
                op_a   = A_W'(err_mag);
                op_b   = sample_period_reg;
                op_neg = err_neg;
            end
            ST_SURF:
            begin
                op_a   = A_W'(integ_mag);
                op_b   = gain_mag;
                op_neg = gain_neg ^ integ_neg;
                op_hi  = 1'b1;
            end
            ST_FRIC:
            begin
                op_a   = A_W'(omega_mag);
                op_b   = B_W'(friction_ratio_reg);
            end
            ST_DIST:
            begin
                op_a   = A_W'(phi_mag);
                op_b   = B_W'(pole_inertia_reg);
                op_neg = phi_neg;
            end
            ST_ERR:
            begin
                op_a   = A_W'(err_mag);
                op_b   = gain_mag;
                op_neg = gain_neg;
            end
            ST_MU:
            begin
                // |sum| < 2^49, top bit always clear
                op_a   = sum_mag[A_W-1:0];
                op_b   = inv_torque_reg;
                op_neg = sum_neg;
                op_hi  = 1'b1;
            end
            ST_GAMMA:
            begin
                op_a   = A_W'(sigma_mag);
                op_b   = gamma_mag;
                op_neg = gamma_neg ^ sigma_neg;
            end
        endcase
    end

    // rescale (truncate toward zero on the magnitude), then apply the sign
    logic [PVAL_W-1:0]        mag_sel;
    logic signed [PVAL_W-1:0] p_val;

    assign mag_sel = op_hi ? PVAL_W'(mul_prod[P_W-1:SHIFT_HI]) :
                             mul_prod[SHIFT_LO +: PVAL_W];
    assign p_val   = op_neg ? -$signed(mag_sel) : $signed(mag_sel);

    // ---------------------------------------------------------------
    // Arithmetic on the product
    // ---------------------------------------------------------------
    logic signed [SUM_W-1:0]   integ_sum;
    logic [SUM_W-INTEG_W:0]    integ_top;
    logic signed [INTEG_W-1:0] integ_sat;
    logic signed [SUM_W-1:0]   sigma_sum;
    logic signed [CMD_W-1:0]   cmd_base;
    logic signed [CMD_W-1:0]   cmd_full;
    logic                      sigma_pos;

    assign integ_sum = SUM_W'(integ_reg) + SUM_W'(p_val);
    assign integ_top = integ_sum[SUM_W-1:INTEG_W-1];
    assign integ_sat = ((&integ_top) || (~|integ_top)) ? integ_sum[INTEG_W-1:0] :
                       (integ_sum[SUM_W-1] ? {1'b1, {(INTEG_W-1){1'b0}}} :
                                             {1'b0, {(INTEG_W-1){1'b1}}});

    assign sigma_sum = SUM_W'(err_reg) + SUM_W'(p_val);

    // command = -gamma*sigma - mu*sign(sigma)
    assign sigma_pos = !sigma_neg && (|sigma_reg);
    assign cmd_base  = -p_val;
    assign cmd_full  = sigma_pos ? cmd_base - CMD_W'(mu_reg) :
                       sigma_neg ? cmd_base + CMD_W'(mu_reg) : cmd_base;

    // ---------------------------------------------------------------
    // Sequencer: next state
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_xfer)  state_next = ST_INT;
            ST_INT:   if (mul_done) state_next = ST_SURF;
            ST_SURF:  if (mul_done) state_next = ST_FRIC;
            ST_FRIC:  if (mul_done) state_next = ST_DIST;
            ST_DIST:  if (mul_done) state_next = ST_ERR;
            ST_ERR:   if (mul_done) state_next = ST_MU;
            ST_MU:    if (mul_done) state_next = ST_GAMMA;
            ST_GAMMA: if (mul_done) state_next = ST_IDLE;
        endcase
    end

    // Sequencer: outputs
    always_comb
    begin
        in_stall  = 1'b1;
        cfg_ready = 1'b0;
        kick_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall  = wait_out;
                cfg_ready = 1'b1;
                kick_next = in_valid && !wait_out;
            end
            ST_INT, ST_SURF, ST_FRIC, ST_DIST, ST_ERR, ST_MU:
            begin
                kick_next = mul_done;
            end
            ST_GAMMA:
            begin
                kick_next = 1'b0;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Datapath next values
    // ---------------------------------------------------------------
    always_comb
    begin
        surface_gain_next      = surface_gain_reg;
        proportional_gain_next = proportional_gain_reg;
        disturbance_bound_next = disturbance_bound_reg;
        sample_period_next     = sample_period_reg;
        inv_torque_next        = inv_torque_reg;
        friction_ratio_next    = friction_ratio_reg;
        pole_inertia_next      = pole_inertia_reg;

        out_valid_next = out_valid_reg;
        out_cmd_next   = out_cmd_reg;
        out_surf_next  = out_surf_reg;
        omega_next     = omega_reg;
        err_next       = err_reg;
        integ_next     = integ_reg;
        sigma_next     = sigma_reg;
        sum_next       = sum_reg;
        mu_next        = mu_reg;
        held_cmd_next  = held_cmd_reg;
        held_surf_next = held_surf_reg;

        if (cfg_xfer)
        begin
            unique case (cfg_index)
                REG_SURFACE_GAIN:        surface_gain_next      = $signed(cfg_data);
                REG_PROPORTIONAL_GAIN:   proportional_gain_next = $signed(cfg_data);
                REG_DISTURBANCE_BOUND:   disturbance_bound_next = $signed(cfg_data);
                REG_SAMPLE_PERIOD:       sample_period_next     = cfg_data;
                REG_INVERSE_TORQUE_GAIN: inv_torque_next        = cfg_data;
                REG_FRICTION_RATIO:      friction_ratio_next    = cfg_data[FRIC_W-1:0];
                REG_POLE_INERTIA_RATIO:  pole_inertia_next      = cfg_data[FRIC_W-1:0];
                default:                 ;
            endcase
        end

        // result of the previous sample goes out as the new one is taken
        if (in_xfer)
        begin
            out_valid_next = 1'b1;
            out_cmd_next   = held_cmd_reg;
            out_surf_next  = held_surf_reg;
            omega_next     = speed_measured;
            err_next       = ERR_W'(speed_measured) - ERR_W'(speed_target);
        end
        else if (out_xfer)
        begin
            out_valid_next = 1'b0;
        end

        if (mul_done)
        begin
            unique case (state_reg)
                ST_INT:   integ_next = integ_sat;
                ST_SURF:  sigma_next = sigma_sum[SIGMA_W-1:0];
                ST_FRIC:  sum_next   = SUM_W'(p_val);
                ST_DIST:  sum_next   = sum_reg + SUM_W'(p_val);
                ST_ERR:   sum_next   = sum_reg + SUM_W'(p_val);
                ST_MU:    mu_next    = MU_W'(p_val);
                ST_GAMMA:
                begin
                    held_cmd_next  = sat_out(cmd_full);
                    held_surf_next = sat_out(CMD_W'(sigma_reg));
                end
                default:  ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Register update
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg             <= ST_IDLE;
            kick_reg              <= 1'b0;
            out_valid_reg         <= 1'b0;
            surface_gain_reg      <= '0;
            proportional_gain_reg <= '0;
            disturbance_bound_reg <= '0;
            sample_period_reg     <= SAMPLE_PERIOD_RST;
            inv_torque_reg        <= INV_TORQUE_RST;
            friction_ratio_reg    <= '0;
            pole_inertia_reg      <= POLE_INERTIA_RST;
            integ_reg             <= '0;
            held_cmd_reg          <= '0;
            held_surf_reg         <= '0;
        end
        else
        begin
            state_reg             <= state_next;
            kick_reg              <= kick_next;
            out_valid_reg         <= out_valid_next;
            surface_gain_reg      <= surface_gain_next;
            proportional_gain_reg <= proportional_gain_next;
            disturbance_bound_reg <= disturbance_bound_next;
            sample_period_reg     <= sample_period_next;
            inv_torque_reg        <= inv_torque_next;
            friction_ratio_reg    <= friction_ratio_next;
            pole_inertia_reg      <= pole_inertia_next;
            integ_reg             <= integ_next;
            held_cmd_reg          <= held_cmd_next;
            held_surf_reg         <= held_surf_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        out_cmd_reg  <= out_cmd_next;
        out_surf_reg <= out_surf_next;
        omega_reg    <= omega_next;
        err_reg      <= err_next;
        sigma_reg    <= sigma_next;
        sum_reg      <= sum_next;
        mu_reg       <= mu_next;
    end

    assign out_valid       = out_valid_reg;
    assign current_command = out_cmd_reg;
    assign surface_value   = out_surf_reg;

endmodule

`default_nettype wire

/* rtl/smc_mul.sv */
// Digit-serial unsigned multiplier, DIGIT_W bits of the B operand per cycle.
// Depends on smc_pkg.
`default_nettype none

module smc_mul
    import smc_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire logic [A_W-1:0] a,
    input  wire logic [B_W-1:0] b,
    output logic                done,
    output logic [P_W-1:0]      product
);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [A_W-1:0]   a_reg, a_next;
    logic [B_W-1:0]   b_reg, b_next;
    logic [P_W-1:0]   acc_reg, acc_next;

    logic [PART_W-1:0] partial;
    logic [PART_W-1:0] upper_sum;
    logic [P_W-1:0]    acc_step;

    // one digit: add A*digit at the top, shift right by a digit
    assign partial   = PART_W'(a_reg) * PART_W'(b_reg[DIGIT_W-1:0]);
    assign upper_sum = PART_W'(acc_reg[P_W-1:B_W]) + partial;
    assign acc_step  = {upper_sum, acc_reg[B_W-1:DIGIT_W]};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            a_next    = a;
            b_next    = b;
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            acc_next = acc_step;
            b_next   = b_reg >> DIGIT_W;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(MUL_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

`default_nettype wire

/* rtl/smc_checker.sv */
// Port-level assertions for the sliding mode speed controller, bound to the top.
// Depends on smc_pkg.
`default_nettype none

module smc_checker
    import smc_pkg::*;
(
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      in_valid,
    input wire logic                      in_stall,
    input wire logic                      out_valid,
    input wire logic                      out_stall,
    input wire logic signed [SPEED_W-1:0] current_command,
    input wire logic signed [SPEED_W-1:0] surface_value,
    input wire logic                      cfg_ready
);

    // a result appears only in answer to an input transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall))
        else $error("result without input transfer");

    // no new sample while a result is held back
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> in_stall)
        else $error("input taken while result stalled");

    // one sample at a time: busy right after a transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (in_stall && !cfg_ready))
        else $error("not busy after input transfer");

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            (out_valid && $stable(current_command) && $stable(surface_value)))
        else $error("stalled result changed");

endmodule

bind sliding_mode_speed_controller smc_checker u_smc_checker (.*);

`default_nettype wire

/* bench/tb_top.sv */
// Self-checking bench for sliding_mode_speed_controller: directed corner samples, then
// phases of random gain settings and speed samples under random source gaps and sink stalls.
// Depends on smc_pkg and the controller RTL; expected results come from the scoreboard class.
module tb_top;
    import smc_pkg::*;

    // Index with no register behind it; writes there must be dropped.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    localparam int RANDOM_SAMPLES = 1700;
    localparam int CYCLE_LIMIT    = 800_000;
    localparam int SETTLE_CYCLES  = 60;      // longer than the product sequence after a transfer
    localparam int MAX_WAIT       = 13;

    localparam logic signed [SPEED_W-1:0] SPEED_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [SPEED_W-1:0] SPEED_MIN = 32'sh8000_0000;

    // Predictor limits: product clamp, Q16.32 integrator range, 32-bit output range.
    localparam logic [127:0] PRODUCT_LIMIT = 128'd1 << 61;
    localparam longint INTEG_MAX = (longint'(1) << 47) - 1;
    localparam longint INTEG_MIN = -(longint'(1) << 47);
    localparam longint OUT_MAX   = 64'sd2147483647;
    localparam longint OUT_MIN   = -64'sd2147483648;

    typedef enum int {STYLE_NOMINAL, STYLE_RANDOM, STYLE_CORNER} setting_style_t;

    typedef struct packed {
        logic signed [SPEED_W-1:0] current_command;
        logic signed [SPEED_W-1:0] surface_value;
    } controller_output_t;

    // Scoreboard: a bit-exact copy of the controller state and gains, plus the
    // queue of outputs that the block still owes us, oldest first.
    class smc_scoreboard;
        logic signed [SPEED_W-1:0] surface_gain;
        logic signed [SPEED_W-1:0] proportional_gain;
        logic signed [SPEED_W-1:0] disturbance_bound;
        logic [SPEED_W-1:0]        sample_period;
        logic [SPEED_W-1:0]        inverse_torque_gain;
        logic [FRIC_W-1:0]         friction_ratio;
        logic [FRIC_W-1:0]         pole_inertia_ratio;
        longint                    error_integral;
        controller_output_t        held;
        controller_output_t        owed_outputs[$];
        int                        failures;

        function new();
            surface_gain        = '0;
            proportional_gain   = '0;
            disturbance_bound   = '0;
            sample_period       = SAMPLE_PERIOD_RST;
            inverse_torque_gain = INV_TORQUE_RST;
            friction_ratio      = '0;
            pole_inertia_ratio  = POLE_INERTIA_RST;
            error_integral      = 0;
            held                = '0;
            failures            = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] index, logic [SPEED_W-1:0] data);
            case (index)
                REG_SURFACE_GAIN:        surface_gain        = data;
                REG_PROPORTIONAL_GAIN:   proportional_gain   = data;
                REG_DISTURBANCE_BOUND:   disturbance_bound   = data;
                REG_SAMPLE_PERIOD:       sample_period       = data;
                REG_INVERSE_TORQUE_GAIN: inverse_torque_gain = data;
                REG_FRICTION_RATIO:      friction_ratio      = data[FRIC_W-1:0];
                REG_POLE_INERTIA_RATIO:  pole_inertia_ratio  = data[FRIC_W-1:0];
                default: ;
            endcase
        endfunction

        // Exact |a|*|b| >> sh, truncated toward zero, clamped to 2^61, sign reapplied.
        function longint scaled_product(longint a, longint b, int sh);
            logic [63:0]  mag_a;
            logic [63:0]  mag_b;
            logic [127:0] wide;
            longint       m;
            mag_a = (a < 0) ? -a : a;
            mag_b = (b < 0) ? -b : b;
            wide  = ({64'd0, mag_a} * {64'd0, mag_b}) >> sh;
            m = (wide > PRODUCT_LIMIT) ? longint'(PRODUCT_LIMIT[63:0]) : longint'(wide[63:0]);
            return ((a < 0) != (b < 0)) ? -m : m;
        endfunction

        function longint clip(longint v, longint lo, longint hi);
            return (v < lo) ? lo : ((v > hi) ? hi : v);
        endfunction

        function int pending();
            return owed_outputs.size();
        endfunction

        // One accepted sample: the block answers with the pair held from the
        // previous sample, then holds the pair computed from this one.
        function void note_sample(logic signed [SPEED_W-1:0] target,
                                  logic signed [SPEED_W-1:0] measured);
            longint omega;
            longint err;
            longint sigma;
            longint sum;
            longint mu;
            longint cmd;
            omega = measured;
            err   = omega - longint'(target);
            owed_outputs.push_back(held);

            error_integral = clip(error_integral +
                                  scaled_product(err, longint'({32'd0, sample_period}), SHIFT_LO),
                                  INTEG_MIN, INTEG_MAX);
            sigma = err + scaled_product(longint'(surface_gain), error_integral, SHIFT_HI);

            sum = scaled_product(longint'({33'd0, friction_ratio}),
                                 (omega < 0) ? -omega : omega, SHIFT_LO)
                + scaled_product(longint'({33'd0, pole_inertia_ratio}),
                                 longint'(disturbance_bound), SHIFT_LO)
                + scaled_product(longint'(surface_gain), (err < 0) ? -err : err, SHIFT_LO);
            mu = scaled_product(longint'({32'd0, inverse_torque_gain}), sum, SHIFT_HI);

            // Sign and gamma term both use the unsaturated surface.
            cmd = -scaled_product(longint'(proportional_gain), sigma, SHIFT_LO);
            if (sigma > 0)
                cmd -= mu;
            else if (sigma < 0)
                cmd += mu;

            held.current_command = 32'(clip(cmd, OUT_MIN, OUT_MAX));
            held.surface_value   = 32'(clip(sigma, OUT_MIN, OUT_MAX));
        endfunction

        function void check_result(logic signed [SPEED_W-1:0] cmd,
                                   logic signed [SPEED_W-1:0] surf);
            controller_output_t want;
            if (owed_outputs.size() == 0)
            begin
                $error("unexpected result: current_command %0d surface_value %0d", cmd, surf);
                failures++;
                return;
            end
            want = owed_outputs.pop_front();
            if (cmd !== want.current_command)
            begin
                $error("current_command: expected %0d, actual %0d", want.current_command, cmd);
                failures++;
            end
            if (surf !== want.surface_value)
            begin
                $error("surface_value: expected %0d, actual %0d", want.surface_value, surf);
                failures++;
            end
        endfunction
    endclass

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_stall;
    logic signed [SPEED_W-1:0]   speed_target;
    logic signed [SPEED_W-1:0]   speed_measured;
    logic                        out_valid;
    logic                        out_stall;
    logic signed [SPEED_W-1:0]   current_command;
    logic signed [SPEED_W-1:0]   surface_value;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [CFG_IDX_W-1:0]        cfg_index;
    logic [SPEED_W-1:0]          cfg_data;

    smc_scoreboard sb;
    bit            source_rushing;   // stretch with no gaps on the sample side
    bit            sink_eager;       // stretch with no stalls on the result side
    int unsigned   cycle_count = 0;

    sliding_mode_speed_controller DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .speed_target    (speed_target),
        .speed_measured  (speed_measured),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .current_command (current_command),
        .surface_value   (surface_value),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    // 8-unit clock period
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // Watchdog: a hung handshake or a lost result ends here.
    initial
    begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("sliding_mode_speed_controller test failed");
        $finish;
    end

    // One sample transfer. Valid is only dropped when a gap is drawn, so a
    // back-to-back sample keeps it high without a second assignment this step.
    task automatic send_sample(input logic signed [SPEED_W-1:0] target,
                               input logic signed [SPEED_W-1:0] measured);
        int gap;
        if ($urandom_range(0, 39) == 0)
            source_rushing = !source_rushing;
        gap = source_rushing ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        speed_target   <= target;
        speed_measured <= measured;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_sample(target, measured);
    endtask

    // One register transfer; the caller drops cfg_valid after the last one.
    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [SPEED_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_register(index, data);
    endtask

    // Full gain setting, plus a write to the empty index that must not land.
    task automatic load_setting(input logic [SPEED_W-1:0] c_omega, gamma, phi, dt, inv_a,
                                input logic [SPEED_W-1:0] fric, pole);
        write_register(REG_SURFACE_GAIN, c_omega);
        write_register(REG_PROPORTIONAL_GAIN, gamma);
        write_register(REG_DISTURBANCE_BOUND, phi);
        write_register(REG_SAMPLE_PERIOD, dt);
        write_register(REG_INVERSE_TORQUE_GAIN, inv_a);
        write_register(REG_FRICTION_RATIO, fric);
        write_register(REG_POLE_INERTIA_RATIO, pole);
        write_register(REG_UNUSED, $urandom());
        cfg_valid <= 1'b0;
    endtask

    // Wait for every owed result, then let the product sequence of the last
    // sample finish before the block is touched again.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [SPEED_W-1:0] signed_span(logic [SPEED_W-1:0] span);
        logic [SPEED_W-1:0] v;
        v = $urandom_range(0, span);
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    function automatic logic [SPEED_W-1:0] pick_value(logic [CFG_IDX_W-1:0] index,
                                                      setting_style_t style);
        if (style == STYLE_RANDOM)
            return $urandom();
        if (style == STYLE_CORNER)
        begin
            case ($urandom_range(0, 4))
                0: return 32'h0000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'h8000_0000;
                3: return 32'hFFFF_FFFF;
                default: return 32'h0000_0001;
            endcase
        end
        // Plausible drive values: gains of a few units, dt from 10 us to 1 ms.
        case (index)
            REG_SURFACE_GAIN:        return signed_span(32'h0032_0000);
            REG_PROPORTIONAL_GAIN:   return signed_span(32'h0002_0000);
            REG_DISTURBANCE_BOUND:   return signed_span(32'h0000_8000);
            REG_SAMPLE_PERIOD:       return $urandom_range(42950, 4294967);
            REG_INVERSE_TORQUE_GAIN: return $urandom_range(0, 32'h0400_0000);
            REG_FRICTION_RATIO:      return $urandom_range(0, 32'h0001_0000);
            default:                 return $urandom_range(0, 32'h0400_0000);
        endcase
    endfunction

    function automatic logic signed [SPEED_W-1:0] speed_corner();
        case ($urandom_range(0, 4))
            0: return SPEED_MAX;
            1: return SPEED_MIN;
            2: return 32'sd0;
            3: return -32'sd1;
            default: return 32'sd1;
        endcase
    endfunction

    // Half the time realistic tracking (measured close to target), with full-range
    // noise, exact matches and corner speeds mixed in.
    function automatic void pick_sample(output logic signed [SPEED_W-1:0] target,
                                        output logic signed [SPEED_W-1:0] measured);
        case ($urandom_range(0, 9))
            0, 1:
            begin
                target   = $urandom();
                measured = $urandom();
            end
            7:
            begin
                target   = $urandom();
                measured = target;
            end
            8:
            begin
                target   = speed_corner();
                measured = speed_corner();
            end
            9:
            begin
                target   = $urandom_range(0, 32'h1000_0000) - 32'h0800_0000;
                measured = $urandom();
            end
            default:
            begin
                target   = $urandom_range(0, 32'h1000_0000) - 32'h0800_0000;
                measured = target + ($urandom_range(0, 32'h0002_0000) - 32'h0001_0000);
            end
        endcase
    endfunction

    // Result side: per result, a stall of up to MAX_WAIT counted from when the
    // result shows up; stall may already be high before valid rises.
    initial
    begin : result_sink
        int hold;
        wait (rst_n === 1'b1);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                sink_eager = !sink_eager;
            hold = sink_eager ? 0 : $urandom_range(0, MAX_WAIT);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                do
                    @(posedge clk);
                while (!out_valid);
                repeat (hold - 1) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
            sb.check_result(current_command, surface_value);
        end
    end

    initial
    begin : stimulus
        logic signed [SPEED_W-1:0] target;
        logic signed [SPEED_W-1:0] measured;
        setting_style_t            style;
        int                        sent;
        int                        phase_len;

        sb             = new();
        source_rushing = 1'b0;
        sink_eager     = 1'b0;
        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        speed_target   <= '0;
        speed_measured <= '0;
        out_stall      <= 1'b0;
        cfg_valid      <= 1'b0;
        cfg_index      <= REG_SURFACE_GAIN;
        cfg_data       <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset gains: first result must be the zero pair; equal speeds give
        // a zero surface; then full-scale errors both ways.
        send_sample(32'sd0, 32'sd0);
        send_sample(32'sd12345, 32'sd12345);
        send_sample(SPEED_MAX, SPEED_MIN);
        send_sample(SPEED_MIN, SPEED_MAX);
        drain();

        // c_omega = 0 so equal speeds leave sigma at zero while mu is large:
        // the switching term must drop out. Max dt drives the integrator
        // into both 48-bit rails and leaves it on the top one.
        load_setting(32'h0000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                     32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_sample(32'sd5, 32'sd5);
        send_sample(SPEED_MIN, SPEED_MAX);
        send_sample(SPEED_MIN, SPEED_MAX);
        send_sample(SPEED_MAX, SPEED_MIN);
        send_sample(SPEED_MAX, SPEED_MIN);
        send_sample(SPEED_MIN, SPEED_MAX);
        send_sample(SPEED_MIN, SPEED_MAX);
        drain();

        // Saturated integrator times full c_omega: gamma*sigma overruns the
        // product clamp and both outputs saturate. Friction data has bit 31 set.
        load_setting(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF,
                     32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
        send_sample(SPEED_MAX, SPEED_MAX);
        send_sample(SPEED_MIN, SPEED_MAX);
        send_sample(32'sd0, -32'sd1);
        send_sample(-32'sd1, 32'sd0);
        drain();

        // Everything at its floor: dt = 0 freezes the integrator.
        load_setting(32'h8000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                     32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_sample(SPEED_MIN, SPEED_MIN);
        send_sample(SPEED_MAX, SPEED_MIN);
        drain();

        // Random phases, each under a fresh gain setting.
        sent = 0;
        while (sent < RANDOM_SAMPLES)
        begin
            style = setting_style_t'($urandom_range(0, 2));
            load_setting(pick_value(REG_SURFACE_GAIN, style),
                         pick_value(REG_PROPORTIONAL_GAIN, style),
                         pick_value(REG_DISTURBANCE_BOUND, style),
                         pick_value(REG_SAMPLE_PERIOD, style),
                         pick_value(REG_INVERSE_TORQUE_GAIN, style),
                         pick_value(REG_FRICTION_RATIO, style),
                         pick_value(REG_POLE_INERTIA_RATIO, style));
            phase_len = $urandom_range(80, 250);
            repeat (phase_len)
            begin
                pick_sample(target, measured);
                send_sample(target, measured);
            end
            sent += phase_len;
            drain();
        end

        if (sb.failures == 0)
            $display("sliding_mode_speed_controller test passed");
        else
            $display("sliding_mode_speed_controller test failed");
        $finish;
    end

endmodule

/* sim.f */
rtl/smc_pkg.sv
rtl/smc_mul.sv
rtl/sliding_mode_speed_controller.sv
rtl/smc_checker.sv
bench/tb_top.sv
